// File: sv/swa_pkg.sv
package swa_pkg;

   // sizing of the window store and the sample path
   localparam int MAX_WINDOW  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int AVG_BITS    = 24;
   localparam int CFG_BITS    = 6;

   // derived widths
   localparam int PTR_BITS  = $clog2(MAX_WINDOW);
   localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS;
   localparam int DIV_BITS  = SUM_BITS + FRAC_BITS;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);

   // request queue between front and back
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

   // one division job: window sum, sample count and end-of-array flag
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic        [CNT_BITS-1:0] count;
      logic                       last;
   } job_type;

endpackage

// File: sv/sliding_window_average_top.sv
// Moving average over arrays of signed 16-bit samples. Each request carries one
// sample and an end-of-array flag; once the configured window is full, every
// request yields the window mean as signed fixed point with 8 fraction bits,
// truncated toward zero, and an array shorter than the window yields the mean
// of all its samples on its final request. The front end reads the window
// store in the cycle it accepts a request and updates the sum in the busy
// state after it; it takes no new request before that update is done. Each
// result passes through a radix-2 restoring divider of 29 steps, framed by a
// load state and an unload state; a two-entry job queue lets the front end
// keep taking requests while the divider works. A write to the window length
// register restarts the array in progress.
module sliding_window_average_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [swa_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   req_last,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [swa_pkg::AVG_BITS-1:0]    rsp_average,
   output logic                                   rsp_last_result,
   input  logic                                   csr_we,
   input  logic [swa_pkg::CFG_BITS-1:0]           csr_wdata
);

   swa_pkg::job_type job;
   swa_pkg::job_type head;
   logic             job_push;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   // window tracking and classification
   swa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .req_last   (req_last),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .job        (job),
      .job_push   (job_push),
      .q_full     (q_full)
   );

   // job queue
   swa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // mean by iterative division
   swa_divider u_divider (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_average     (rsp_average),
      .rsp_last_result (rsp_last_result),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop)
   );

endmodule

// File: sv/swa_ram.sv
module swa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: sv/swa_front.sv
module swa_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [swa_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   req_last,
   input  logic                                   csr_we,
   input  logic [swa_pkg::CFG_BITS-1:0]           csr_wdata,
   output swa_pkg::job_type                       job,
   output logic                                   job_push,
   input  logic                                   q_full
);

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   state_type                              state_ff, state_in;
   logic        [swa_pkg::CFG_BITS-1:0]    wlen_ff, wlen_in;
   logic signed [swa_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic        [swa_pkg::CNT_BITS-1:0]    fill_ff, fill_in;
   logic        [swa_pkg::PTR_BITS-1:0]    wp_ff, wp_in;
   logic signed [swa_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                                   last_ff, last_in;

   logic        [swa_pkg::CNT_BITS-1:0]    k;
   logic        [swa_pkg::PTR_BITS:0]      oldest_sum;
   logic        [swa_pkg::PTR_BITS-1:0]    oldest;
   logic        [swa_pkg::PTR_BITS-1:0]    wp_next;
   logic        [swa_pkg::SAMPLE_BITS-1:0] rd_data;
   logic signed [swa_pkg::SUM_BITS-1:0]    sub_ext;
   logic signed [swa_pkg::SUM_BITS-1:0]    sum_next;
   logic        [swa_pkg::CNT_BITS-1:0]    fill_next;
   logic                                   accept;

   // effective window: zero means one, large values saturate
   always_comb begin
      if (wlen_ff == '0) begin
         k = swa_pkg::CNT_BITS'(1);
      end else if (32'(wlen_ff) > swa_pkg::MAX_WINDOW) begin
         k = swa_pkg::CNT_BITS'(swa_pkg::MAX_WINDOW);
      end else begin
         k = swa_pkg::CNT_BITS'(wlen_ff);
      end
   end

   // ring slot of the sample that leaves the window
   always_comb begin
      oldest_sum = {1'b0, wp_ff} + (swa_pkg::PTR_BITS + 1)'(swa_pkg::MAX_WINDOW)
                   - (swa_pkg::PTR_BITS + 1)'(k);
      if (32'(oldest_sum) >= swa_pkg::MAX_WINDOW) begin
         oldest = swa_pkg::PTR_BITS'(32'(oldest_sum) - swa_pkg::MAX_WINDOW);
      end else begin
         oldest = swa_pkg::PTR_BITS'(oldest_sum);
      end
      if (32'(wp_ff) == swa_pkg::MAX_WINDOW - 1) begin
         wp_next = '0;
      end else begin
         wp_next = wp_ff + 1'b1;
      end
   end

   // window store, read in the accept cycle, written in the busy state that follows
   swa_ram #(
      .WIDTH (swa_pkg::SAMPLE_BITS),
      .DEPTH (swa_pkg::MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (state_ff == S_BUSY),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (oldest),
      .rd_data (rd_data)
   );

   // window update and result classification
   always_comb begin
      sub_ext   = (fill_ff >= k) ? swa_pkg::SUM_BITS'($signed(rd_data)) : '0;
      sum_next  = sum_ff - sub_ext + swa_pkg::SUM_BITS'(sample_ff);
      fill_next = (fill_ff < k) ? fill_ff + 1'b1 : fill_ff;
      job_push  = (state_ff == S_BUSY) && ((fill_next >= k) || last_ff);
      job.sum   = sum_next;
      job.count = fill_next;
      job.last  = last_ff;
   end

   assign req_full = (state_ff != S_IDLE) || q_full;
   assign accept   = req_push && !req_full;

   // next state and array state
   always_comb begin
      state_in  = state_ff;
      wlen_in   = wlen_ff;
      sum_in    = sum_ff;
      fill_in   = fill_ff;
      wp_in     = wp_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               last_in   = req_last;
               state_in  = S_BUSY;
            end
         end
         S_BUSY: begin
            state_in = S_IDLE;
            if (last_ff) begin
               sum_in  = '0;
               fill_in = '0;
               wp_in   = '0;
            end else begin
               sum_in  = sum_next;
               fill_in = fill_next;
               wp_in   = wp_next;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // register write restarts the array
      if (csr_we) begin
         wlen_in = csr_wdata;
         sum_in  = '0;
         fill_in = '0;
         wp_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wlen_ff  <= swa_pkg::CFG_BITS'(1);
         sum_ff   <= '0;
         fill_ff  <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wlen_ff  <= wlen_in;
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         wp_ff    <= wp_in;
      end
      sample_ff <= sample_in;
      last_ff   <= last_in;
   end

   // a job always finds room, since room was checked at accept
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("job pushed into a full queue");

   // a job never carries a zero divisor nor a count above MAX_WINDOW
   a_job_count: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job.count != '0) && (32'(job.count) <= swa_pkg::MAX_WINDOW))
      else $error("job count out of range");

   // the fill count never passes the window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> (fill_ff <= k))
      else $error("fill count beyond window");

endmodule

// File: sv/swa_queue.sv
module swa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  swa_pkg::job_type push_job,
   input  logic             pop,
   output swa_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   swa_pkg::job_type                 slot_ff [swa_pkg::QDEPTH];
   logic [swa_pkg::QPTR_BITS-1:0]    wr_ff, wr_in;
   logic [swa_pkg::QPTR_BITS-1:0]    rd_ff, rd_in;
   logic [swa_pkg::QCNT_BITS-1:0]    cnt_ff, cnt_in;

   assign full  = (32'(cnt_ff) == swa_pkg::QDEPTH);
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (32'(wr_ff) == swa_pkg::QDEPTH - 1) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (32'(rd_ff) == swa_pkg::QDEPTH - 1) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   // the back side only takes a job that is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

// File: sv/swa_divider.sv
module swa_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  swa_pkg::job_type                    head,
   input  logic                                q_empty,
   output logic                                q_pop,
   output logic signed [swa_pkg::AVG_BITS-1:0] rsp_average,
   output logic                                rsp_last_result,
   output logic                                rsp_empty,
   input  logic                                rsp_pop
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [swa_pkg::DIV_BITS-1:0]  dvd_ff, dvd_in;
   logic [swa_pkg::CNT_BITS-1:0]  rem_ff, rem_in;
   logic [swa_pkg::CNT_BITS-1:0]  dsr_ff, dsr_in;
   logic [swa_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                          neg_ff, neg_in;
   logic                          jlast_ff, jlast_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [swa_pkg::AVG_BITS-1:0] avg_ff, avg_in;
   logic                          olast_ff, olast_in;

   logic [swa_pkg::SUM_BITS-1:0]  mag;
   logic [swa_pkg::CNT_BITS:0]    rem_shift;
   logic                          fits;
   logic [swa_pkg::DIV_BITS-1:0]  q_signed;
   logic                          load_out;

   // magnitude of the window sum
   assign mag = head.sum[swa_pkg::SUM_BITS-1] ? swa_pkg::SUM_BITS'(-head.sum)
                                              : swa_pkg::SUM_BITS'(head.sum);

   // one restoring division step
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[swa_pkg::DIV_BITS-1]};
      fits      = (rem_shift >= {1'b0, dsr_ff});
      q_signed  = neg_ff ? -dvd_ff : dvd_ff;
   end

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign load_out = (state_ff == S_DONE) && (!out_valid_ff || rsp_pop);

   // sequencer
   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      jlast_in = jlast_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               dvd_in   = swa_pkg::DIV_BITS'(mag) << swa_pkg::FRAC_BITS;
               rem_in   = '0;
               dsr_in   = head.count;
               neg_in   = head.sum[swa_pkg::SUM_BITS-1];
               jlast_in = head.last;
               step_in  = swa_pkg::STEP_BITS'(swa_pkg::DIV_BITS);
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            rem_in  = fits ? swa_pkg::CNT_BITS'(rem_shift - {1'b0, dsr_ff})
                           : swa_pkg::CNT_BITS'(rem_shift);
            dvd_in  = {dvd_ff[swa_pkg::DIV_BITS-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == swa_pkg::STEP_BITS'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      avg_in       = avg_ff;
      olast_in     = olast_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         avg_in       = swa_pkg::AVG_BITS'(q_signed);
         olast_in     = jlast_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      jlast_ff <= jlast_in;
      avg_ff   <= avg_in;
      olast_ff <= olast_in;
   end

   assign rsp_average     = avg_ff;
   assign rsp_last_result = olast_ff;
   assign rsp_empty       = !out_valid_ff;

   // the divisor is never zero while iterating
   a_dsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (dsr_ff != '0))
      else $error("division by zero count");

   // a finished quotient waits while the result register is taken
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_valid_ff && !rsp_pop) |=>
         (state_ff == S_DONE) && $stable(dvd_ff))
      else $error("quotient lost while result register busy");

endmodule
